### rtl/core/unsorted_array_priority_queue_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the unsorted array priority queue
// Clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef UNSORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define UNSORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define UAPQ_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uapq assertion failed");

// next-cycle implication
`define UAPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uapq assertion failed");

`endif

### rtl/core/uapq_pkg.sv
// ---------------------------------------------------------------------------
// uapq_pkg
// Sizes, codes and shared types of the unsorted array priority queue.
// ---------------------------------------------------------------------------
package uapq_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int PRIO_WIDTH  = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam int IN_BITS  = VALUE_WIDTH + PRIO_WIDTH;
  localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = VALUE_WIDTH + PRIO_WIDTH + CNT_W;
  localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic signed [PRIO_WIDTH-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic             valid;
    entry_t           ent;
    logic [IDX_W-1:0] idx;
  } scan_t;

  typedef struct packed {
    logic wr;
    logic shift;
    logic live;
    logic take_lowest;
  } cell_ctl_t;

endpackage

### rtl/core/unsorted_array_priority_queue.sv
// ---------------------------------------------------------------------------
// unsorted_array_priority_queue
// Priority queue of up to DEPTH entries kept in arrival order in a row of
// slots; dequeue removes the lowest or highest priority, oldest on ties.
// ---------------------------------------------------------------------------
// Usage:
//   Input word (s_axis): tdata = item_value, item_priority;
//   tuser = cmd (0 enqueue, 1 dequeue), take_lowest.
//   Output word (m_axis): one per input; tuser = status (ok, full, empty);
//   tdata = out_value, out_priority, fill_count.
//   Enqueue, full enqueue and empty dequeue: the accept moves the block to
//   its done state, from which the result word goes into the output register.
//   Dequeue of a held entry: a candidate wave walks all DEPTH slots one slot
//   per cycle, then the word goes into the output register; the removal
//   shifts all later slots down together. One word at a time: the next is
//   taken once the current result is in the output register; s_axis_tready_o
//   is high while idle, also while a finished word still waits on m_axis.
//   A stalled receiver holds the output word; the next result waits in the
//   block until the output register frees up.
//   Reset empties the queue and drops any pending output word; slot
//   contents are not cleared, only the fill count.
// ---------------------------------------------------------------------------
module unsorted_array_priority_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [uapq_pkg::IN_DW-1:0]   s_axis_tdata_i,  // item_value, item_priority
  input  logic [1:0]                   s_axis_tuser_i,  // cmd, take_lowest
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [uapq_pkg::OUT_DW-1:0]  m_axis_tdata_o,  // out_value, out_priority,
                                                        // fill_count, zero pad
  output logic [1:0]                   m_axis_tuser_o   // status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int VW = uapq_pkg::VALUE_WIDTH;
  localparam int PW = uapq_pkg::PRIO_WIDTH;
  localparam int CW = uapq_pkg::CNT_W;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q;
  logic          tl_q;
  logic          m_valid_q;

  logic [1:0]          res_status_q;
  uapq_pkg::entry_t    res_entry_q;
  logic [uapq_pkg::OUT_DW-1:0] m_data_q;
  logic [1:0]          m_user_q;

  logic in_acc, is_deq, is_full, is_empty, enq_ok, deq_go, rm_go, out_free;
  uapq_pkg::entry_t in_entry;

  uapq_pkg::entry_t    entries [uapq_pkg::DEPTH];
  uapq_pkg::entry_t    nbrs    [uapq_pkg::DEPTH];
  uapq_pkg::cell_ctl_t ctls    [uapq_pkg::DEPTH];
  uapq_pkg::scan_t     scans   [uapq_pkg::DEPTH+1];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_deq   = (s_axis_tuser_i[0] == uapq_pkg::CMD_DEQ);
  assign is_full  = (count_q == CW'(uapq_pkg::DEPTH));
  assign is_empty = (count_q == '0);
  assign enq_ok   = in_acc && !is_deq && !is_full;
  assign deq_go   = in_acc && is_deq && !is_empty;
  assign rm_go    = (state_q == S_SCAN) && scans[uapq_pkg::DEPTH].valid;
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign in_entry.value = s_axis_tdata_i[VW-1:0];
  assign in_entry.prio  = s_axis_tdata_i[VW+PW-1:VW];

  always_comb begin
    scans[0]       = '0;
    scans[0].valid = deq_go;
  end

  for (genvar k = 0; k < uapq_pkg::DEPTH; k++) begin : g_cell
    if (k == uapq_pkg::DEPTH - 1) begin : g_tail
      assign nbrs[k] = '0;
    end else begin : g_body
      assign nbrs[k] = entries[k+1];
    end

    always_comb begin
      ctls[k].wr          = enq_ok && (count_q == CW'(k));
      ctls[k].shift       = rm_go && (CW'(k) >= CW'(scans[uapq_pkg::DEPTH].idx))
                            && (CW'(k + 1) < count_q);
      ctls[k].live        = (CW'(k) < count_q);
      ctls[k].take_lowest = tl_q;
    end

    uapq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (uapq_pkg::IDX_W'(k)),
      .ctl_i       (ctls[k]),
      .wr_entry_i  (in_entry),
      .nbr_entry_i (nbrs[k]),
      .entry_o     (entries[k]),
      .scan_i      (scans[k]),
      .scan_o      (scans[k+1])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = deq_go ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (rm_go) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      tl_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (enq_ok) begin
        count_q <= count_q + CW'(1);
      end else if (rm_go) begin
        count_q <= count_q - CW'(1);
      end
      if (in_acc) begin
        tl_q <= s_axis_tuser_i[1];
      end
      if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_entry_q <= '0;
      if (is_deq) begin
        res_status_q <= is_empty ? uapq_pkg::STATUS_EMPTY : uapq_pkg::STATUS_OK;
      end else begin
        res_status_q <= is_full ? uapq_pkg::STATUS_FULL : uapq_pkg::STATUS_OK;
      end
    end else if (rm_go) begin
      res_entry_q  <= scans[uapq_pkg::DEPTH].ent;
      res_status_q <= uapq_pkg::STATUS_OK;
    end
    if (state_q == S_DONE && out_free) begin
      m_data_q <= uapq_pkg::OUT_DW'({count_q, res_entry_q.prio, res_entry_q.value});
      m_user_q <= res_status_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

### rtl/core/uapq_cell.sv
// ---------------------------------------------------------------------------
// uapq_cell
// One queue slot: holds an entry, shifts down from its neighbor on removal,
// and forwards the running best candidate of a dequeue scan by one stage.
// ---------------------------------------------------------------------------
module uapq_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [uapq_pkg::IDX_W-1:0]  cell_idx_i,
  input  uapq_pkg::cell_ctl_t         ctl_i,
  input  uapq_pkg::entry_t            wr_entry_i,
  input  uapq_pkg::entry_t            nbr_entry_i,
  output uapq_pkg::entry_t            entry_o,
  input  uapq_pkg::scan_t             scan_i,
  output uapq_pkg::scan_t             scan_o
);

  uapq_pkg::entry_t entry_q;
  uapq_pkg::scan_t  scan_d, scan_q;
  logic             better;
  logic             take;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      entry_q <= wr_entry_i;
    end else if (ctl_i.shift) begin
      entry_q <= nbr_entry_i;
    end
  end

  // strict compare keeps the oldest entry on ties; slot 0 seeds the scan
  always_comb begin
    better = ctl_i.take_lowest ? (entry_q.prio < scan_i.ent.prio)
                               : (entry_q.prio > scan_i.ent.prio);
    take   = scan_i.valid && ctl_i.live && ((cell_idx_i == '0) || better);
    scan_d = scan_i;
    if (take) begin
      scan_d.ent = entry_q;
      scan_d.idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign entry_o = entry_q;
  assign scan_o  = scan_q;

endmodule

### rtl/core/uapq_sva.sv
// ---------------------------------------------------------------------------
// uapq_sva
// Port-level checks of the unsorted array priority queue, bound to the top.
// ---------------------------------------------------------------------------
`include "unsorted_array_priority_queue_macros.svh"

module uapq_sva (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [uapq_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  input logic [1:0]                   m_axis_tuser_o
);

  localparam int FC_LO = uapq_pkg::VALUE_WIDTH + uapq_pkg::PRIO_WIDTH;
  localparam int FC_HI = FC_LO + uapq_pkg::CNT_W - 1;

  logic [uapq_pkg::CNT_W-1:0]  fill;
  logic [uapq_pkg::OUT_DW+1:0] out_word;
  logic                        in_acc, out_stall, out_empty, out_full;

  assign fill      = m_axis_tdata_o[FC_HI:FC_LO];
  assign out_word  = {m_axis_tuser_o, m_axis_tdata_o};
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_empty = m_axis_tvalid_o && (m_axis_tuser_o == uapq_pkg::STATUS_EMPTY);
  assign out_full  = m_axis_tvalid_o && (m_axis_tuser_o == uapq_pkg::STATUS_FULL);

  `UAPQ_ASSERT_NEXT(a_stall_hold, out_stall, m_axis_tvalid_o && $stable(out_word))
  `UAPQ_ASSERT_NEXT(a_accept_busy, in_acc, !s_axis_tready_o)
  `UAPQ_ASSERT(a_fill_range, m_axis_tvalid_o, fill <= uapq_pkg::CNT_W'(uapq_pkg::DEPTH))
  `UAPQ_ASSERT(a_empty_fill, out_empty, fill == '0)
  `UAPQ_ASSERT(a_full_fill, out_full, fill == uapq_pkg::CNT_W'(uapq_pkg::DEPTH))

endmodule

bind unsorted_array_priority_queue uapq_sva u_uapq_sva (.*);

### tb/tb_unsorted_array_priority_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_unsorted_array_priority_queue
// Drives enqueue and dequeue words into the priority queue with bursty input
// and a stalling output side. Every result word is compared field by field
// with a bench queue model or a table row. A directed table covers empty,
// full, extreme priorities, ties and ignored fields. A random run follows.
// ---------------------------------------------------------------------------
module tb_unsorted_array_priority_queue;
  import uapq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF       = 600;
  localparam int RANDOM_WORDS   = 2000;

  typedef struct packed {
    logic [1:0]                    status;
    logic signed [VALUE_WIDTH-1:0] value;
    logic signed [PRIO_WIDTH-1:0]  prio;
    logic [CNT_W-1:0]              fill;
  } result_t;

  typedef struct {
    logic                   cmd;
    logic [VALUE_WIDTH-1:0] value;
    logic [PRIO_WIDTH-1:0]  prio;
    logic                   take_lowest;
    int                     reps;
    bit                     rnd;
    bit                     typed;
    result_t                want;
  } step_row_t;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_tvalid = 1'b0;
  logic [IN_DW-1:0]   s_tdata = '0;
  logic [1:0]         s_tuser = '0;
  logic               m_tready = 1'b0;
  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic [OUT_DW-1:0]  m_axis_tdata_o;
  logic [1:0]         m_axis_tuser_o;

  // side data traveling with the word on s_axis
  bit                 row_typed = 1'b0;
  result_t            row_want = '0;

  logic signed [VALUE_WIDTH-1:0] held_value [DEPTH];
  logic signed [PRIO_WIDTH-1:0]  held_prio [DEPTH];
  int                 held_count = 0;
  result_t            pending_results [$];
  step_row_t          directed_rows [$];
  int                 errors = 0;
  int                 words_in = 0;
  int                 burst_left = 0;

  unsorted_array_priority_queue i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // item_value, item_priority
    .s_axis_tuser_i  (s_tuser),   // cmd, take_lowest
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // out_value, out_priority, fill_count
    .m_axis_tuser_o  (m_axis_tuser_o)   // status
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  function automatic result_t apply_queue_op(logic cmd, logic signed [VALUE_WIDTH-1:0] v,
                                             logic signed [PRIO_WIDTH-1:0] p, logic lowest);
    result_t r;
    int      pick;
    r = '0;
    r.status = STATUS_OK;
    if (cmd == CMD_ENQ) begin
      if (held_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        held_value[held_count] = v;
        held_prio[held_count] = p;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      pick = 0;
      // strict compare keeps the oldest entry on ties
      for (int i = 1; i < held_count; i++) begin
        if (lowest ? (held_prio[i] < held_prio[pick]) : (held_prio[i] > held_prio[pick]))
          pick = i;
      end
      r.value = held_value[pick];
      r.prio = held_prio[pick];
      for (int i = pick; i < held_count - 1; i++) begin
        held_value[i] = held_value[i + 1];
        held_prio[i] = held_prio[i + 1];
      end
      held_count--;
    end
    r.fill = CNT_W'(held_count);
    return r;
  endfunction

  function automatic logic [PRIO_WIDTH-1:0] rand_prio();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3, 4, 5: return PRIO_WIDTH'(int'($urandom_range(0, 8)) - 4);
      default: return PRIO_WIDTH'($urandom);
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic add_row(input logic cmd, input logic [VALUE_WIDTH-1:0] v,
                         input logic [PRIO_WIDTH-1:0] p, input logic tl, input int reps,
                         input bit rnd, input bit typed, input logic [1:0] st,
                         input logic [VALUE_WIDTH-1:0] ov, input logic [PRIO_WIDTH-1:0] op,
                         input int fill);
    step_row_t row;
    row.cmd = cmd;
    row.value = v;
    row.prio = p;
    row.take_lowest = tl;
    row.reps = reps;
    row.rnd = rnd;
    row.typed = typed;
    row.want.status = st;
    row.want.value = ov;
    row.want.prio = op;
    row.want.fill = CNT_W'(fill);
    directed_rows.push_back(row);
  endtask

  task automatic send_word(input logic cmd, input logic [VALUE_WIDTH-1:0] v,
                           input logic [PRIO_WIDTH-1:0] p, input logic tl,
                           input bit typed, input result_t want);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {p, v};
    s_tuser <= {tl, cmd};
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // monitor: predict on input accept, check on output accept
  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t got;
    if (rst_n) begin
      if (s_tvalid && s_axis_tready_o) begin
        want = apply_queue_op(s_tuser[0], s_tdata[VALUE_WIDTH-1:0],
                              s_tdata[VALUE_WIDTH+:PRIO_WIDTH], s_tuser[1]);
        if (row_typed) want = row_want;
        pending_results.push_back(want);
        words_in++;
      end
      if (m_axis_tvalid_o && m_tready) begin
        got.status = m_axis_tuser_o;
        got.value = m_axis_tdata_o[VALUE_WIDTH-1:0];
        got.prio = m_axis_tdata_o[VALUE_WIDTH+:PRIO_WIDTH];
        got.fill = m_axis_tdata_o[VALUE_WIDTH+PRIO_WIDTH+:CNT_W];
        if (pending_results.size() == 0) begin
          report("word with nothing pending, value", got.value, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
          if (got.value !== want.value) report("out_value", got.value, want.value);
          if (got.prio !== want.prio)
            report("out_priority", 32'(got.prio), 32'(want.prio));
          if (got.fill !== want.fill)
            report("fill_count", 32'(got.fill), 32'(want.fill));
        end
      end
    end
  end

  // output side: stall patterns plus one long hold-off to back the queue up
  initial begin : receiver
    int  mode;
    int  len;
    bit  hold_done;
    hold_done = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(20, 200);
      repeat (len) begin
        @(posedge clk_i);
        if (!hold_done && words_in >= 400) begin
          hold_done = 1'b1;
          m_tready <= 1'b0;
          repeat (HOLD_OFF) @(posedge clk_i);
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_n);
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) idle = 0;
      else idle++;
    end
    $display("unsorted_array_priority_queue verification failed");
    $finish;
  end

  initial begin : stimulus
    step_row_t              row;
    logic [VALUE_WIDTH-1:0] v;
    logic [PRIO_WIDTH-1:0]  p;
    logic                   tl;
    logic                   cmd;
    int                     enq_pct;
    int                     seg_left;
    int                     sent;

    add_row(CMD_DEQ, '0, '0, 1'b1, 1, 0, 1, STATUS_EMPTY, '0, '0, 0);
    add_row(CMD_DEQ, '1, '1, 1'b0, 1, 0, 1, STATUS_EMPTY, '0, '0, 0);
    add_row(CMD_ENQ, 32'h7fffffff, 16'h8000, 1'b0, 1, 0, 1, STATUS_OK, '0, '0, 1);
    add_row(CMD_ENQ, 32'h80000000, 16'h7fff, 1'b1, 1, 0, 1, STATUS_OK, '0, '0, 2);
    add_row(CMD_ENQ, '0, '0, 1'b0, 1, 0, 1, STATUS_OK, '0, '0, 3);
    add_row(CMD_ENQ, 32'hffffffff, 16'h7fff, 1'b0, 1, 0, 1, STATUS_OK, '0, '0, 4);
    add_row(CMD_ENQ, 32'd5, 16'h8000, 1'b0, 1, 0, 1, STATUS_OK, '0, '0, 5);
    // ties at both extremes: oldest wins
    add_row(CMD_DEQ, '0, '0, 1'b0, 1, 0, 1, STATUS_OK, 32'h80000000, 16'h7fff, 4);
    add_row(CMD_DEQ, '0, '0, 1'b1, 1, 0, 1, STATUS_OK, 32'h7fffffff, 16'h8000, 3);
    // payload fields ignored on dequeue, take_lowest ignored on enqueue
    add_row(CMD_DEQ, '1, '1, 1'b1, 1, 0, 1, STATUS_OK, 32'd5, 16'h8000, 2);
    add_row(CMD_ENQ, 32'd123, 16'hffff, 1'b1, 1, 0, 1, STATUS_OK, '0, '0, 3);
    add_row(CMD_DEQ, '0, '0, 1'b0, 1, 0, 1, STATUS_OK, 32'hffffffff, 16'h7fff, 2);
    add_row(CMD_DEQ, '0, '0, 1'b1, 1, 0, 0, STATUS_OK, '0, '0, 0);
    // fill up, overflow, then drain past empty
    add_row(CMD_ENQ, '0, '0, 1'b0, DEPTH - 1, 1, 0, STATUS_OK, '0, '0, 0);
    add_row(CMD_ENQ, 32'h1234, 16'h1, 1'b0, 1, 0, 1, STATUS_FULL, '0, '0, DEPTH);
    add_row(CMD_DEQ, '0, '0, 1'b0, 40, 1, 0, STATUS_OK, '0, '0, 0);
    add_row(CMD_ENQ, '0, '0, 1'b0, 10, 1, 0, STATUS_OK, '0, '0, 0);
    add_row(CMD_DEQ, '0, '0, 1'b0, 40, 1, 0, STATUS_OK, '0, '0, 0);
    add_row(CMD_DEQ, '1, '1, 1'b1, 1, 0, 1, STATUS_EMPTY, '0, '0, 0);

    wait (rst_n);
    @(posedge clk_i);
    burst_left = $urandom_range(0, 40);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      repeat (row.reps) begin
        v = row.value;
        p = row.prio;
        tl = row.take_lowest;
        if (row.rnd) begin
          v = $urandom;
          p = rand_prio();
          tl = 1'($urandom_range(0, 1));
        end
        send_word(row.cmd, v, p, tl, row.typed, row.want);
      end
    end

    // random segments lean toward filling, draining or mixing
    seg_left = 0;
    enq_pct = 50;
    for (sent = 0; sent < RANDOM_WORDS; sent++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 100);
        case ($urandom_range(0, 2))
          0: enq_pct = 85;
          1: enq_pct = 50;
          default: enq_pct = 15;
        endcase
      end
      seg_left--;
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      send_word(cmd, $urandom, rand_prio(), 1'($urandom_range(0, 1)), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("unsorted_array_priority_queue verification clean");
    end else begin
      $display("unsorted_array_priority_queue verification failed");
    end
    $finish;
  end

endmodule
